// File: hw/rtl/hsl2rgb_pkg.sv
// Constants shared by the HSL to RGB conversion pipeline.
`timescale 1ns / 1ps

package hsl2rgb_pkg;

  // Hue scale: one full turn and one 60 degree sector in 1/16 degree.
  localparam logic [15:0] HUE_TURN   = 16'd5760;
  localparam logic [15:0] HUE_BIAS   = 16'd17280;
  localparam logic [12:0] HUE_SECTOR = 13'd960;

  // Unit value of saturation and lightness in Q.12.
  localparam logic [12:0] ONE_Q12 = 13'd4096;

  // Half of the common denominator 960 * 2^24, used for rounding half up.
  localparam logic [42:0] ROUND_HALF = 43'd480 << 24;

  // Reciprocal of 15 scaled by 2^18; exact floor for every 13-bit dividend.
  localparam logic [14:0] RECIP15       = 15'd17477;
  localparam int unsigned RECIP15_SHIFT = 18;

  // Hue sectors, named by the largest and the intermediate channel.
  localparam logic [2:0] SEC_RG = 3'd0;
  localparam logic [2:0] SEC_GR = 3'd1;
  localparam logic [2:0] SEC_GB = 3'd2;
  localparam logic [2:0] SEC_BG = 3'd3;
  localparam logic [2:0] SEC_BR = 3'd4;
  localparam logic [2:0] SEC_RB = 3'd5;

  // Channel value before rounding, over the common denominator.
  typedef logic [34:0] chan_sum_t;

endpackage

// File: hw/rtl/hsl_to_rgb_convert_top.sv
// HSL to RGB conversion: seven register stages, a new pixel every cycle unless the output stalls.
// Throughput is one word per cycle; each stage holds when the one after it is full and stalled.
// The constant multiply chain (chroma, intermediate component, rounding) sets the stage count.
// Reset (rst, synchronous, active high) clears all stage valid bits; data registers are not reset.
`timescale 1ns / 1ps

module hsl_to_rgb_convert_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: hue[14:0], saturation[28:15], lightness[42:29], zero fill.
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: red[7:0], green[15:8], blue[23:16].
  output logic [23:0] m_axis_tdata
);

  localparam int NSTG = 7;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  // Stage enables: a stage loads when it is empty or the next one moves.
  always_comb begin
    en[NSTG-1] = ~vld[NSTG-1] | m_axis_tready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = ~vld[i] | en[i+1];
    end
  end

  assign s_axis_tready = en[0];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // ---------------- Stage 1: hue wrap, saturation and lightness clamp
  logic signed [14:0] hue_in;
  logic signed [13:0] sat_in;
  logic signed [13:0] lit_in;
  logic [15:0]        hue_b;
  logic [2:0]         turns;
  logic [15:0]        hue_w;
  logic [12:0]        sat_c;
  logic [12:0]        lit_c;
  logic [12:0]        h1;
  logic [12:0]        s1;
  logic [12:0]        l1;

  function automatic logic [15:0] HUE_BIAS_ADD(input logic signed [14:0] h);
    logic signed [16:0] hx;
    hx = 17'(h) + 17'(signed'({1'b0, hsl2rgb_pkg::HUE_BIAS}));
    return hx[15:0];
  endfunction

  function automatic logic [12:0] clamp_unit(input logic signed [13:0] v);
    logic [12:0] r;
    if (v < 14'sd0) begin
      r = 13'd0;
    end else if (v > 14'sd4096) begin
      r = hsl2rgb_pkg::ONE_Q12;
    end else begin
      r = v[12:0];
    end
    return r;
  endfunction

  assign hue_in = s_axis_tdata[14:0];
  assign sat_in = s_axis_tdata[28:15];
  assign lit_in = s_axis_tdata[42:29];

  // Bias by three turns so the value is positive, then count whole turns.
  always_comb begin
    hue_b = HUE_BIAS_ADD(hue_in);
    turns = 3'd0;
    for (int j = 1; j <= 5; j++) begin
      if (hue_b >= 16'(j * 5760)) begin
        turns = 3'(j);
      end
    end
    hue_w = hue_b - 16'(turns * hsl2rgb_pkg::HUE_TURN);
  end

  assign sat_c = clamp_unit(sat_in);
  assign lit_c = clamp_unit(lit_in);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      h1 <= hue_w[12:0];
      s1 <= sat_c;
      l1 <= lit_c;
    end
  end

  // ---------------- Stage 2: chroma factor, sector and intermediate weight
  logic [2:0]  sec_n;
  logic [12:0] hm;
  logic [12:0] wd;
  logic [13:0] l_dbl;
  logic [12:0] cd_n;
  logic [2:0]  sec2;
  logic [10:0] w2;
  logic [12:0] cd2;
  logic [12:0] s2;
  logic [12:0] l2;

  always_comb begin
    sec_n = hsl2rgb_pkg::SEC_RG;
    for (int j = 1; j <= 5; j++) begin
      if (h1 >= 13'(j * 960)) begin
        sec_n = 3'(j);
      end
    end
    // Hue modulo two sectors, then distance from the sector edge.
    hm = h1 - 13'({1'b0, sec_n[2:1]} * 13'd1920);
    wd = (hm >= hsl2rgb_pkg::HUE_SECTOR) ? hm - hsl2rgb_pkg::HUE_SECTOR
                                         : hsl2rgb_pkg::HUE_SECTOR - hm;
    // 1 - |2L - 1| in Q.12.
    l_dbl = {l1, 1'b0};
    cd_n  = (l1 < 13'd2048) ? l_dbl[12:0] : 13'(14'd8192 - l_dbl);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sec2 <= sec_n;
      w2   <= 11'(hsl2rgb_pkg::HUE_SECTOR - wd);
      cd2  <= cd_n;
      s2   <= s1;
      l2   <= l1;
    end
  end

  // ---------------- Stage 3: chroma in Q.24
  logic [24:0] c3;
  logic [2:0]  sec3;
  logic [10:0] w3;
  logic [12:0] l3;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c3   <= 25'(cd2) * 25'(s2);
      sec3 <= sec2;
      w3   <= w2;
      l3   <= l2;
    end
  end

  // ---------------- Stage 4: scaled chroma, intermediate and offset
  logic [33:0] cs_n;
  logic [33:0] ls_n;
  logic [23:0] l960;
  logic [33:0] cs4;
  logic [33:0] xs4;
  logic [33:0] ms4;
  logic [2:0]  sec4;

  assign cs_n = (34'(c3) << 10) - (34'(c3) << 6);
  assign l960 = (24'(l3) << 10) - (24'(l3) << 6);
  assign ls_n = 34'(l960) << 12;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      cs4  <= cs_n;
      xs4  <= 34'(c3) * 34'(w3);
      ms4  <= ls_n - (cs_n >> 1);
      sec4 <= sec3;
    end
  end

  // ---------------- Stage 5: channel sums by sector
  hsl2rgb_pkg::chan_sum_t r_n, g_n, b_n;
  hsl2rgb_pkg::chan_sum_t sum5 [3];

  always_comb begin
    case (sec4)
      hsl2rgb_pkg::SEC_RG: begin r_n = 35'(cs4); g_n = 35'(xs4); b_n = '0;         end
      hsl2rgb_pkg::SEC_GR: begin r_n = 35'(xs4); g_n = 35'(cs4); b_n = '0;         end
      hsl2rgb_pkg::SEC_GB: begin r_n = '0;       g_n = 35'(cs4); b_n = 35'(xs4);   end
      hsl2rgb_pkg::SEC_BG: begin r_n = '0;       g_n = 35'(xs4); b_n = 35'(cs4);   end
      hsl2rgb_pkg::SEC_BR: begin r_n = 35'(xs4); g_n = '0;       b_n = 35'(cs4);   end
      default: begin             r_n = 35'(cs4); g_n = '0;       b_n = 35'(xs4);   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      sum5[0] <= r_n + 35'(ms4);
      sum5[1] <= g_n + 35'(ms4);
      sum5[2] <= b_n + 35'(ms4);
    end
  end

  // ---------------- Stages 6 and 7: scale by 255, round, divide by 960 * 2^24
  logic [12:0] u6 [3];
  logic [7:0]  ch7 [3];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [42:0] scaled;
    logic [27:0] prod;
    logic [9:0]  quo;

    // v * 255 + D/2, then drop 2^30 (2^24 and the factor 64 of 960).
    assign scaled = (43'(sum5[c]) << 8) - 43'(sum5[c]) + hsl2rgb_pkg::ROUND_HALF;

    always_ff @(posedge clk) begin
      if (en[5]) begin
        u6[c] <= scaled[42:30];
      end
    end

    // Divide the remaining factor 15 by reciprocal multiply, then clamp.
    assign prod = 28'(u6[c]) * 28'(hsl2rgb_pkg::RECIP15);
    assign quo  = prod[hsl2rgb_pkg::RECIP15_SHIFT +: 10];

    always_ff @(posedge clk) begin
      if (en[6]) begin
        ch7[c] <= (quo > 10'd255) ? 8'd255 : quo[7:0];
      end
    end
  end

  assign m_axis_tvalid = vld[NSTG-1];
  assign m_axis_tdata  = {ch7[2], ch7[1], ch7[0]};

endmodule

// File: test/hsl_to_rgb_convert_top_test.sv
// Self-checking testbench for the HSL to RGB pixel converter with stream handshakes.
`timescale 1ns / 1ps

module hsl_to_rgb_convert_top_test;

  // One input pixel, packed in tdata order from bit 0: hue, saturation, lightness.
  typedef struct packed {
    logic signed [13:0] lightness;
    logic signed [13:0] saturation;
    logic signed [14:0] hue;
  } hsl_pixel_t;

  // One output pixel, packed in tdata order from bit 0: red, green, blue.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_pixel_t;

  localparam int STALL_LIMIT    = 1000;
  localparam int LONG_HOLD      = 120;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_REPORTS    = 10;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // Fields from bit 0: hue[14:0], saturation[28:15], lightness[42:29], zero fill.
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // Fields from bit 0: red[7:0], green[15:8], blue[23:16].
  logic [23:0] m_axis_tdata;

  rgb_pixel_t  rgb_expect_q[$];
  int          mismatch_count = 0;
  int          stall_cycles = 0;
  bit          src_idle_on = 1'b0;
  bit          sink_idle_on = 1'b0;
  bit          sink_hold_req = 1'b0;

  hsl_to_rgb_convert_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Scale one channel sum over the common denominator to 0..255, rounding half up.
  function automatic logic [7:0] scale_channel(longint sum, longint denom);
    longint level;
    if (sum < 0) sum = 0;
    level = (sum * 255 + denom / 2) / denom;
    if (level > 255) level = 255;
    return level[7:0];
  endfunction

  // Clamp a Q.12 value into 0..1.0.
  function automatic int clamp_q12(int v);
    if (v < 0) return 0;
    if (v > int'(hsl2rgb_pkg::ONE_Q12)) return int'(hsl2rgb_pkg::ONE_Q12);
    return v;
  endfunction

  // Exact integer HSL to RGB conversion over the denominator 960 * 2^24.
  function automatic rgb_pixel_t convert_hsl(hsl_pixel_t px);
    int         hue_pos;
    int         sat;
    int         light;
    int         light_dev;
    int         weight;
    int         sector;
    int         turn;
    int         one;
    int         sec_w;
    longint     chroma;
    longint     denom;
    longint     full_c;
    longint     mid_x;
    longint     offset;
    longint     r_sum;
    longint     g_sum;
    longint     b_sum;
    rgb_pixel_t rgb;
    turn  = int'(hsl2rgb_pkg::HUE_TURN);
    one   = int'(hsl2rgb_pkg::ONE_Q12);
    sec_w = int'(hsl2rgb_pkg::HUE_SECTOR);
    hue_pos = int'(px.hue) % turn;
    if (hue_pos < 0) hue_pos += turn;
    sat   = clamp_q12(int'(px.saturation));
    light = clamp_q12(int'(px.lightness));
    light_dev = 2 * light - one;
    if (light_dev < 0) light_dev = -light_dev;
    chroma = longint'(one - light_dev) * longint'(sat);
    sector = hue_pos / sec_w;
    weight = (hue_pos % (2 * sec_w)) - sec_w;
    if (weight < 0) weight = -weight;
    weight = sec_w - weight;
    denom  = longint'(one) * longint'(one) * longint'(sec_w);
    full_c = chroma * longint'(sec_w);
    mid_x  = chroma * longint'(weight);
    offset = longint'(light) * longint'(one) * longint'(sec_w)
             - chroma * longint'(sec_w / 2);
    case (3'(sector))
      hsl2rgb_pkg::SEC_RG: begin r_sum = full_c; g_sum = mid_x;  b_sum = 0;      end
      hsl2rgb_pkg::SEC_GR: begin r_sum = mid_x;  g_sum = full_c; b_sum = 0;      end
      hsl2rgb_pkg::SEC_GB: begin r_sum = 0;      g_sum = full_c; b_sum = mid_x;  end
      hsl2rgb_pkg::SEC_BG: begin r_sum = 0;      g_sum = mid_x;  b_sum = full_c; end
      hsl2rgb_pkg::SEC_BR: begin r_sum = mid_x;  g_sum = 0;      b_sum = full_c; end
      default: begin r_sum = full_c; g_sum = 0;     b_sum = mid_x;  end
    endcase
    rgb.red   = scale_channel(r_sum + offset, denom);
    rgb.green = scale_channel(g_sum + offset, denom);
    rgb.blue  = scale_channel(b_sum + offset, denom);
    return rgb;
  endfunction

  function automatic hsl_pixel_t make_pixel(int hue, int sat, int light);
    hsl_pixel_t px;
    px.hue        = hue[14:0];
    px.saturation = sat[13:0];
    px.lightness  = light[13:0];
    return px;
  endfunction

  // Mostly wide-range pixels, some with edge values, the rest raw bit patterns.
  function automatic hsl_pixel_t random_pixel();
    hsl_pixel_t px;
    int         pick;
    int         edges[6] = '{-4096, -1, 0, 4096, 4097, 8191};
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      px = hsl_pixel_t'(43'({$urandom, $urandom}));
    end else begin
      px = make_pixel(int'($urandom_range(0, 17279)) - 5760,
                      int'($urandom_range(0, 12287)) - 4096,
                      int'($urandom_range(0, 12287)) - 4096);
      if (pick == 2) px.saturation = 14'(edges[$urandom_range(0, 5)]);
      if (pick == 3) px.lightness  = 14'(edges[$urandom_range(0, 5)]);
    end
    return px;
  endfunction

  // Offer one word and wait until it is taken; record the expected pixel.
  task automatic send_pixel(hsl_pixel_t px);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, px};
    do @(posedge clk); while (!s_axis_tready);
    rgb_expect_q.push_back(convert_hsl(px));
  endtask

  task automatic drop_valid();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (rgb_expect_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall bursts, or one long hold on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        sink_hold_req = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare every output word with the oldest expected pixel.
  always @(posedge clk) begin
    rgb_pixel_t got;
    rgb_pixel_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = rgb_pixel_t'(m_axis_tdata);
      if (rgb_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("Unexpected output word: r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
      end else begin
        want = rgb_expect_q.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("Mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.red, want.green, want.blue, got.red, got.green, got.blue);
        end
      end
    end
  end

  // Watchdog on cycles in which neither side moves a word.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Hue wrap, sector boundaries, clamping of saturation and lightness, raw extremes.
  task automatic test_directed();
    hsl_pixel_t list[$];
    list.push_back(make_pixel(0, 4096, 2048));
    list.push_back(make_pixel(960, 4096, 2048));
    list.push_back(make_pixel(1920, 4096, 2048));
    list.push_back(make_pixel(2880, 4096, 2048));
    list.push_back(make_pixel(3840, 4096, 2048));
    list.push_back(make_pixel(4800, 4096, 2048));
    list.push_back(make_pixel(480, 4096, 2048));
    list.push_back(make_pixel(5759, 4096, 2048));
    list.push_back(make_pixel(-5760, 4096, 2048));
    list.push_back(make_pixel(11519, 4096, 2048));
    list.push_back(make_pixel(5760, 3000, 1500));
    list.push_back(make_pixel(-1, 3000, 2500));
    list.push_back(make_pixel(-16384, 8191, 8191));
    list.push_back(make_pixel(16383, -8192, -8192));
    list.push_back(make_pixel(1000, -4096, 2048));
    list.push_back(make_pixel(1000, 8191, 2048));
    list.push_back(make_pixel(2000, 4097, 2048));
    list.push_back(make_pixel(2000, -1, 2048));
    list.push_back(make_pixel(3000, 4096, -4096));
    list.push_back(make_pixel(3000, 4096, 8191));
    list.push_back(make_pixel(4000, 4096, 0));
    list.push_back(make_pixel(4000, 4096, 4096));
    list.push_back(make_pixel(1234, 0, 2048));
    list.push_back(make_pixel(300, 4095, 4095));
    list.push_back(make_pixel(5000, 2048, 1));
    foreach (list[i]) send_pixel(list[i]);
  endtask

  // Bulk random pixels with idle bursts on both sides.
  task automatic test_random(int count);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    repeat (count) send_pixel(random_pixel());
  endtask

  // Receiver holds off while the sender keeps offering, so the pipeline fills up.
  task automatic test_backpressure();
    src_idle_on   = 1'b0;
    sink_hold_req = 1'b1;
    repeat (80) send_pixel(random_pixel());
    src_idle_on = 1'b1;
  endtask

  // Sender stops until every expected pixel has come out, then resumes.
  task automatic test_drain_pause();
    repeat (30) send_pixel(random_pixel());
    drop_valid();
    wait_for_drain();
    repeat (30) send_pixel(random_pixel());
  endtask

  // Final stretch at full rate with no idling on either side.
  task automatic test_full_rate();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    repeat (250) send_pixel(random_pixel());
  endtask

  // Test sequence.
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1100);
    test_backpressure();
    test_drain_pause();
    test_full_rate();
    drop_valid();
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && rgb_expect_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: hsl_to_rgb_convert_top.f
hw/rtl/hsl2rgb_pkg.sv
hw/rtl/hsl_to_rgb_convert_top.sv
test/hsl_to_rgb_convert_top_test.sv
